/* hdl/ssra_pkg.sv */
// shared types and constants for the spike-reject averager
// no dependencies
`default_nettype none

package ssra_pkg;

  // sample word format, signed q16.16
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned FRAC_W    = 16;
  localparam int unsigned LIMIT_W   = 31;
  localparam int unsigned CFG_IDX_W = 2;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN        = 2'd0,
    CFG_BIAS        = 2'd1,
    CFG_SPIKE_LIMIT = 2'd2,
    CFG_CLEANSE_EN  = 2'd3
  } cfg_idx_e;

  // register reset values
  localparam logic [DATA_W-1:0]  GAIN_RST    = 32'h0001_0000;
  localparam logic [DATA_W-1:0]  BIAS_RST    = 32'h0000_0000;
  localparam logic [LIMIT_W-1:0] LIMIT_RST   = 31'd6554;
  localparam logic               CLEANSE_RST = 1'b1;

  // one configuration write
  typedef struct packed {
    logic                we;
    cfg_idx_e            idx;
    logic [DATA_W-1:0]   data;
  } cfg_wr_t;

endpackage

`default_nettype wire

/* hdl/ssra_if.sv */
// valid/ready channel interfaces for samples and results
// depends on ssra_pkg
`default_nettype none

// raw sample channel
interface ssra_in_if import ssra_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] raw_sample;

  modport source (output valid, output raw_sample, input ready);
  modport sink   (input valid, input raw_sample, output ready);
endinterface

// result channel
interface ssra_out_if import ssra_pkg::*; #(
  parameter int unsigned CNT_W = 7
) ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] clean_value;
  logic signed [DATA_W-1:0] history_mean;
  logic [CNT_W-1:0]         fill_count;

  modport source (output valid, output clean_value, output history_mean,
                  output fill_count, input ready);
  modport sink   (input valid, input clean_value, input history_mean,
                  input fill_count, output ready);
endinterface

`default_nettype wire

/* hdl/ssra_queue.sv */
// two-word queue between the front and back halves
// no dependencies
`default_nettype none

module ssra_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             wr_valid_i,
  output logic                  wr_ready_o,
  input  wire logic [WIDTH-1:0] wr_data_i,
  output logic                  rd_valid_o,
  input  wire logic             rd_ready_i,
  output logic [WIDTH-1:0]      rd_data_o
);

  logic [WIDTH-1:0] slot_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       cnt_q;
  logic             push, pop;

  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign rd_data_o  = slot_q[rd_ptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  // pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      if (push && !pop)      cnt_q <= cnt_q + 2'd1;
      else if (pop && !push) cnt_q <= cnt_q - 2'd1;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push) slot_q[wr_ptr_q] <= wr_data_i;
  end

endmodule

`default_nettype wire

/* hdl/ssra_front.sv */
// front half: config registers, scaling, spike rejection, ring history
// depends on ssra_pkg
`default_nettype none

module ssra_front import ssra_pkg::*; #(
  parameter int unsigned HISTORY_DEPTH = 64,
  localparam int unsigned SLOT_W = $clog2(HISTORY_DEPTH),
  localparam int unsigned CNT_W  = $clog2(HISTORY_DEPTH + 1)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire cfg_wr_t           cfg_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [DATA_W-1:0] in_raw_i,
  output logic                   push_valid_o,
  input  wire logic              push_ready_i,
  output logic [DATA_W-1:0]      push_val_o,
  output logic [DATA_W-1:0]      push_evict_o,
  output logic                   push_full_o,
  output logic [CNT_W-1:0]       push_cnt_o
);

  typedef enum logic [1:0] {
    F_IDLE = 2'b01,
    F_COND = 2'b10
  } front_state_e;

  localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam int unsigned PROD_W = 2 * DATA_W;
  localparam int unsigned SCL_W  = PROD_W - FRAC_W;

  front_state_e       state_q, state_d;
  logic [DATA_W-1:0]  gain_q, bias_q;
  logic [LIMIT_W-1:0] limit_q;
  logic               cln_en_q;
  logic [DATA_W-1:0]  raw_q, evict_q, prev_q;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic [SLOT_W-1:0]  slot_q;
  logic [CNT_W-1:0]   cnt_q, cnt_nxt;
  logic [DATA_W-1:0]  hist_mem [HISTORY_DEPTH];

  logic               accept, push;
  logic [SCL_W:0]     biased;
  logic [DATA_W-1:0]  sat_val, val;
  logic [DATA_W:0]    diff, diff_mag;
  logic               ovf, spike, full;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q   <= GAIN_RST;
      bias_q   <= BIAS_RST;
      limit_q  <= LIMIT_RST;
      cln_en_q <= CLEANSE_RST;
    end else if (cfg_i.we) begin
      unique case (cfg_i.idx)
        CFG_GAIN:        gain_q   <= cfg_i.data;
        CFG_BIAS:        bias_q   <= cfg_i.data;
        CFG_SPIKE_LIMIT: limit_q  <= cfg_i.data[LIMIT_W-1:0];
        CFG_CLEANSE_EN:  cln_en_q <= cfg_i.data[0];
        default:         gain_q   <= gain_q;
      endcase
    end
  end

  assign in_ready_o = (state_q == F_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign prod_d     = $signed(in_raw_i) * $signed(gain_q);

  // floor shift, bias, saturation
  assign biased  = {prod_q[PROD_W-1], prod_q[PROD_W-1:FRAC_W]}
                 + {{(SCL_W+1-DATA_W){bias_q[DATA_W-1]}}, bias_q};
  assign ovf     = !((&biased[SCL_W:DATA_W-1]) || !(|biased[SCL_W:DATA_W-1]));
  assign sat_val = ovf ? (biased[SCL_W] ? SAT_MIN : SAT_MAX) : biased[DATA_W-1:0];

  // spike test against the last stored value
  assign diff     = {sat_val[DATA_W-1], sat_val} - {prev_q[DATA_W-1], prev_q};
  assign diff_mag = diff[DATA_W] ? (~diff + 1'b1) : diff;
  assign spike    = (cnt_q != '0) && (diff_mag > {2'b00, limit_q});
  assign val      = !cln_en_q ? raw_q : (spike ? prev_q : sat_val);

  // ring bookkeeping
  assign full    = (cnt_q == CNT_W'(HISTORY_DEPTH));
  assign cnt_nxt = full ? cnt_q : cnt_q + 1'b1;
  assign push    = (state_q == F_COND) && push_ready_i;

  assign push_valid_o = (state_q == F_COND);
  assign push_val_o   = val;
  assign push_evict_o = evict_q;
  assign push_full_o  = full;
  assign push_cnt_o   = cnt_nxt;

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      F_IDLE:  if (accept) state_d = F_COND;
      F_COND:  if (push) state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      slot_q  <= '0;
      cnt_q   <= '0;
      prev_q  <= '0;
    end else begin
      state_q <= state_d;
      if (push) begin
        slot_q <= (slot_q == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 : slot_q + 1'b1;
        cnt_q  <= cnt_nxt;
        prev_q <= val;
      end
    end
  end

  // sample capture and multiply
  always_ff @(posedge clk_i) begin
    if (accept) begin
      raw_q  <= in_raw_i;
      prod_q <= prod_d;
    end
  end

  // history memory, oldest word read on accept
  always_ff @(posedge clk_i) begin
    if (accept) evict_q <= hist_mem[slot_q];
    if (push)   hist_mem[slot_q] <= val;
  end

endmodule

`default_nettype wire

/* hdl/ssra_back.sv */
// back half: running total and pipelined mean divider
// depends on ssra_pkg
`default_nettype none

module ssra_back import ssra_pkg::*; #(
  parameter int unsigned HISTORY_DEPTH = 64,
  localparam int unsigned CNT_W = $clog2(HISTORY_DEPTH + 1)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              ent_valid_i,
  output logic                   ent_ready_o,
  input  wire logic [DATA_W-1:0] ent_val_i,
  input  wire logic [DATA_W-1:0] ent_evict_i,
  input  wire logic              ent_full_i,
  input  wire logic [CNT_W-1:0]  ent_cnt_i,
  output logic                   res_valid_o,
  input  wire logic              res_ready_i,
  output logic [DATA_W-1:0]      res_clean_o,
  output logic [DATA_W-1:0]      res_mean_o,
  output logic [CNT_W-1:0]       res_cnt_o
);

  localparam int unsigned SUM_W = DATA_W + $clog2(HISTORY_DEPTH);
  localparam int unsigned EXT_W = SUM_W - DATA_W;

  typedef struct packed {
    logic              neg;
    logic [DATA_W-1:0] val;
    logic [CNT_W-1:0]  cnt;
    logic [CNT_W-1:0]  rem;
    logic [SUM_W-1:0]  dq;
  } div_stage_t;

  logic              adv, pop;
  logic [SUM_W-1:0]  total_q;
  logic              acc_vld_q;
  logic [DATA_W-1:0] acc_val_q;
  logic [CNT_W-1:0]  acc_cnt_q;
  logic [SUM_W-1:0]  evict_ext;
  logic              st_vld_q [SUM_W+1];
  div_stage_t        st_q     [SUM_W+1];
  logic              res_valid_q;
  logic [DATA_W-1:0] res_clean_q, res_mean_q;
  logic [CNT_W-1:0]  res_cnt_q;
  logic [SUM_W-1:0]  quo_fix;

  // whole pipeline freezes while a finished word is not taken
  assign adv         = !(res_valid_q && !res_ready_i);
  assign ent_ready_o = adv;
  assign pop         = ent_valid_i && adv;
  assign evict_ext   = ent_full_i ? {{EXT_W{ent_evict_i[DATA_W-1]}}, ent_evict_i} : '0;

  // running total with eviction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q   <= '0;
      acc_vld_q <= 1'b0;
    end else if (adv) begin
      acc_vld_q <= pop;
      if (pop) total_q <= total_q + {{EXT_W{ent_val_i[DATA_W-1]}}, ent_val_i} - evict_ext;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      acc_val_q <= ent_val_i;
      acc_cnt_q <= ent_cnt_i;
    end
  end

  // magnitude stage feeding the divider
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) st_vld_q[0] <= 1'b0;
    else if (adv) st_vld_q[0] <= acc_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv && acc_vld_q) begin
      st_q[0].neg <= total_q[SUM_W-1];
      st_q[0].val <= acc_val_q;
      st_q[0].cnt <= acc_cnt_q;
      st_q[0].rem <= '0;
      st_q[0].dq  <= total_q[SUM_W-1] ? (~total_q + 1'b1) : total_q;
    end
  end

  // restoring divide, one quotient bit per stage
  for (genvar i = 1; i <= SUM_W; i++) begin : g_div
    logic [CNT_W:0] part;
    logic           ge;
    logic [CNT_W:0] part_sub;

    assign part     = {st_q[i-1].rem, st_q[i-1].dq[SUM_W-1]};
    assign ge       = (part >= {1'b0, st_q[i-1].cnt});
    assign part_sub = part - {1'b0, st_q[i-1].cnt};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) st_vld_q[i] <= 1'b0;
      else if (adv) st_vld_q[i] <= st_vld_q[i-1];
    end

    always_ff @(posedge clk_i) begin
      if (adv && st_vld_q[i-1]) begin
        st_q[i].neg <= st_q[i-1].neg;
        st_q[i].val <= st_q[i-1].val;
        st_q[i].cnt <= st_q[i-1].cnt;
        st_q[i].rem <= ge ? part_sub[CNT_W-1:0] : part[CNT_W-1:0];
        st_q[i].dq  <= {st_q[i-1].dq[SUM_W-2:0], ge};
      end
    end
  end

  // sign fix and result register
  assign quo_fix = st_q[SUM_W].neg ? (~st_q[SUM_W].dq + 1'b1) : st_q[SUM_W].dq;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) res_valid_q <= 1'b0;
    else if (adv) res_valid_q <= st_vld_q[SUM_W];
  end

  always_ff @(posedge clk_i) begin
    if (adv && st_vld_q[SUM_W]) begin
      res_clean_q <= st_q[SUM_W].val;
      res_mean_q  <= quo_fix[DATA_W-1:0];
      res_cnt_q   <= st_q[SUM_W].cnt;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_clean_o = res_clean_q;
  assign res_mean_o  = res_mean_q;
  assign res_cnt_o   = res_cnt_q;

endmodule

`default_nettype wire

/* hdl/sensor_spike_reject_averager_core.sv */
// top level of the spike-reject moving-average sensor conditioner
// depends on ssra_pkg, ssra_if, ssra_queue, ssra_front, ssra_back
//
//   port        dir   flow            word
//   sample_i    in    valid/ready     raw_sample q16.16
//   result_o    out   valid/ready     clean_value, history_mean, fill_count
//   cfg_*_i     in    write enable    gain, bias, spike_limit, cleanse_enable
//
// the front takes a new sample only once the last one is pushed: accepting it
// registers the 32x32 multiply and the history read; the push state does the
// saturation, the spike compare and the ring update. the back adds into the
// running total and divides one quotient bit per stage.
// reset clears control state; history words are unknown until written.
// a stalled result freezes the back, the two-word queue fills, the front stops.
`default_nettype none

module sensor_spike_reject_averager_core import ssra_pkg::*; #(
  parameter int unsigned HISTORY_DEPTH = 64
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  ssra_in_if.sink                   sample_i,
  ssra_out_if.source                result_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [DATA_W-1:0]    cfg_data_i
);

  localparam int unsigned CNT_W = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned ENT_W = 2 * DATA_W + 1 + CNT_W;

  cfg_wr_t           cfg_wr;
  logic              push_valid, push_ready;
  logic [DATA_W-1:0] push_val, push_evict;
  logic              push_full;
  logic [CNT_W-1:0]  push_cnt;
  logic [ENT_W-1:0]  q_wr_data, q_rd_data;
  logic              q_rd_valid, q_rd_ready;

  assign cfg_wr.we   = cfg_we_i;
  assign cfg_wr.idx  = cfg_idx_e'(cfg_idx_i);
  assign cfg_wr.data = cfg_data_i;

  // classify and store
  ssra_front #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_wr),
    .in_valid_i   (sample_i.valid),
    .in_ready_o   (sample_i.ready),
    .in_raw_i     (sample_i.raw_sample),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_val_o   (push_val),
    .push_evict_o (push_evict),
    .push_full_o  (push_full),
    .push_cnt_o   (push_cnt)
  );

  // decoupling queue
  assign q_wr_data = {push_val, push_evict, push_full, push_cnt};

  ssra_queue #(
    .WIDTH (ENT_W)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (push_valid),
    .wr_ready_o (push_ready),
    .wr_data_i  (q_wr_data),
    .rd_valid_o (q_rd_valid),
    .rd_ready_i (q_rd_ready),
    .rd_data_o  (q_rd_data)
  );

  // total and mean
  ssra_back #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ent_valid_i (q_rd_valid),
    .ent_ready_o (q_rd_ready),
    .ent_val_i   (q_rd_data[ENT_W-1 -: DATA_W]),
    .ent_evict_i (q_rd_data[CNT_W+DATA_W : CNT_W+1]),
    .ent_full_i  (q_rd_data[CNT_W]),
    .ent_cnt_i   (q_rd_data[CNT_W-1:0]),
    .res_valid_o (result_o.valid),
    .res_ready_i (result_o.ready),
    .res_clean_o (result_o.clean_value),
    .res_mean_o  (result_o.history_mean),
    .res_cnt_o   (result_o.fill_count)
  );

endmodule

`default_nettype wire
